/* src/gtc_pkg.sv */
// Shared types and constants for the graph transitive closure block.
`default_nettype none
package gtc_pkg;

   localparam int ROW_W = 64;
   localparam int COL_W = 6;
   localparam int CNT_W = 7;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_CLOSE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic             load;
      logic             step;
      logic             rotate;
      logic [COL_W-1:0] pivot;
   } lane_ctl_type;

endpackage
`default_nettype wire

/* src/gtc_lane.sv */
// One row lane: holds a matrix row, applies the Warshall update and rotates rows.
`default_nettype none
module gtc_lane (
   input  wire logic                       clock,
   input  wire gtc_pkg::lane_ctl_type      lane_ctl,
   input  wire logic                       load_sel,
   input  wire logic                       is_tail,
   input  wire logic [gtc_pkg::ROW_W-1:0]  load_row,
   input  wire logic [gtc_pkg::ROW_W-1:0]  col_mask,
   input  wire logic [gtc_pkg::ROW_W-1:0]  next_row,
   input  wire logic [gtc_pkg::ROW_W-1:0]  head_row,
   output logic      [gtc_pkg::ROW_W-1:0]  row_out
);

   logic [gtc_pkg::ROW_W-1:0] row_ff;
   logic [gtc_pkg::ROW_W-1:0] row_in;
   logic [gtc_pkg::ROW_W-1:0] src_row;
   logic [gtc_pkg::ROW_W-1:0] src_masked;
   logic [gtc_pkg::ROW_W-1:0] head_masked;

   assign src_row     = is_tail ? head_row : next_row;
   assign src_masked  = src_row & col_mask;
   assign head_masked = head_row & col_mask;

   always_comb begin
      row_in = row_ff;
      if (lane_ctl.load && load_sel) begin
         row_in = load_row & col_mask;
      end else if (lane_ctl.step) begin
         row_in = src_masked
                | (src_masked[lane_ctl.pivot] ? head_masked : '0);
      end else if (lane_ctl.rotate) begin
         row_in = src_row;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   assign row_out = row_ff;

endmodule
`default_nettype wire

/* src/gtc_ctrl.sv */
// Sequencer for row loading, closure passes and result emission.
`default_nettype none
module gtc_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [gtc_pkg::CNT_W-1:0]  row_count,
   input  wire logic [gtc_pkg::ROW_W-1:0]  head_row,
   output logic                            busy,
   output gtc_pkg::lane_ctl_type           lane_ctl,
   output logic      [gtc_pkg::CNT_W-1:0]  rows_loaded,
   output logic                            rsp_valid,
   output logic      [gtc_pkg::ROW_W-1:0]  rsp_reach_row,
   output logic      [gtc_pkg::COL_W-1:0]  rsp_row_index,
   output logic                            rsp_last_row
);

   gtc_pkg::state_type            state_ff;
   gtc_pkg::state_type            state_in;
   logic [gtc_pkg::CNT_W-1:0]     rows_loaded_ff;
   logic [gtc_pkg::CNT_W-1:0]     rows_loaded_in;
   logic [gtc_pkg::COL_W-1:0]     step_ff;
   logic [gtc_pkg::COL_W-1:0]     step_in;
   logic                          rsp_valid_ff;
   logic [gtc_pkg::ROW_W-1:0]     rsp_row_ff;
   logic [gtc_pkg::COL_W-1:0]     rsp_index_ff;
   logic                          rsp_last_ff;
   logic                          accept;
   logic                          last_step;
   logic                          run_done;
   logic [gtc_pkg::CNT_W-1:0]     loaded_next;

   assign accept      = start && (state_ff == gtc_pkg::ST_LOAD);
   assign loaded_next = rows_loaded_ff + gtc_pkg::CNT_W'(1);
   assign run_done    = (loaded_next >= row_count);
   assign last_step   = ({1'b0, step_ff} == (row_count - gtc_pkg::CNT_W'(1)));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gtc_pkg::ST_LOAD: begin
            if (accept && run_done) state_in = gtc_pkg::ST_CLOSE;
         end
         gtc_pkg::ST_CLOSE: begin
            if (last_step) state_in = gtc_pkg::ST_EMIT;
         end
         gtc_pkg::ST_EMIT: begin
            if (last_step) state_in = gtc_pkg::ST_LOAD;
         end
         default: state_in = gtc_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      busy            = (state_ff != gtc_pkg::ST_LOAD);
      lane_ctl.load   = accept;
      lane_ctl.step   = (state_ff == gtc_pkg::ST_CLOSE);
      lane_ctl.rotate = (state_ff == gtc_pkg::ST_EMIT);
      lane_ctl.pivot  = step_ff;
   end

   always_comb begin
      rows_loaded_in = rows_loaded_ff;
      if (accept) begin
         rows_loaded_in = run_done ? '0 : loaded_next;
      end
      step_in = '0;
      if (state_ff != gtc_pkg::ST_LOAD) begin
         step_in = last_step ? '0 : step_ff + gtc_pkg::COL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= gtc_pkg::ST_LOAD;
         rows_loaded_ff <= '0;
         step_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rows_loaded_ff <= rows_loaded_in;
         step_ff        <= step_in;
         rsp_valid_ff   <= (state_ff == gtc_pkg::ST_EMIT);
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff   <= head_row;
      rsp_index_ff <= step_ff;
      rsp_last_ff  <= last_step;
   end

   assign rows_loaded   = rows_loaded_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_reach_row = rsp_row_ff;
   assign rsp_row_index = rsp_index_ff;
   assign rsp_last_row  = rsp_last_ff;

endmodule
`default_nettype wire

/* src/graph_transitive_closure.sv */
// Transitive closure of a directed graph by Warshall iteration over parallel row lanes.
// Each request loads one adjacency row; a request that ends a run of n rows
// starts n closure passes (one pivot per cycle, all rows updated at once by the lanes),
// then n results follow on consecutive cycles after the closure passes.
// Busy stays high while the closure passes run and rows are emitted; results cannot be stalled.
// Synchronous reset sets the vertex count to 64 and clears the loaded-row count.
`default_nettype none
module graph_transitive_closure #(
   parameter int MAX_VERTICES = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [gtc_pkg::ROW_W-1:0]  req_adjacency_row,
   input  wire logic                       csr_wr_en,
   input  wire logic [gtc_pkg::CNT_W-1:0]  csr_wr_data,
   output logic                            rsp_valid,
   output logic      [gtc_pkg::ROW_W-1:0]  rsp_reach_row,
   output logic      [gtc_pkg::COL_W-1:0]  rsp_row_index,
   output logic                            rsp_last_row
);

   localparam logic [gtc_pkg::CNT_W-1:0] MaxCount = gtc_pkg::CNT_W'(MAX_VERTICES);

   logic [gtc_pkg::CNT_W-1:0]  vertex_count_ff;
   logic [gtc_pkg::CNT_W-1:0]  row_count;
   logic [gtc_pkg::CNT_W-1:0]  rows_loaded;
   logic [gtc_pkg::ROW_W-1:0]  col_mask;
   gtc_pkg::lane_ctl_type      lane_ctl;
   logic [gtc_pkg::ROW_W-1:0]  lane_row [MAX_VERTICES];

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= gtc_pkg::CNT_W'(64);
      end else if (csr_wr_en) begin
         vertex_count_ff <= csr_wr_data;
      end
   end

   always_comb begin
      row_count = vertex_count_ff;
      if (vertex_count_ff == '0) row_count = gtc_pkg::CNT_W'(1);
      else if (vertex_count_ff > MaxCount) row_count = MaxCount;
      for (int j = 0; j < gtc_pkg::ROW_W; j++) begin
         col_mask[j] = (gtc_pkg::CNT_W'(j) < row_count);
      end
   end

   gtc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .row_count     (row_count),
      .head_row      (lane_row[0]),
      .busy          (busy),
      .lane_ctl      (lane_ctl),
      .rows_loaded   (rows_loaded),
      .rsp_valid     (rsp_valid),
      .rsp_reach_row (rsp_reach_row),
      .rsp_row_index (rsp_row_index),
      .rsp_last_row  (rsp_last_row)
   );

   for (genvar p = 0; p < MAX_VERTICES; p++) begin : g_lane
      logic [gtc_pkg::ROW_W-1:0] next_row;

      if (p == MAX_VERTICES - 1) begin : g_wrap
         assign next_row = lane_row[0];
      end else begin : g_chain
         assign next_row = lane_row[p+1];
      end

      gtc_lane u_lane (
         .clock    (clock),
         .lane_ctl (lane_ctl),
         .load_sel (rows_loaded == gtc_pkg::CNT_W'(p)),
         .is_tail  ((row_count - gtc_pkg::CNT_W'(1)) == gtc_pkg::CNT_W'(p)),
         .load_row (req_adjacency_row),
         .col_mask (col_mask),
         .next_row (next_row),
         .head_row (lane_row[0]),
         .row_out  (lane_row[p])
      );
   end

endmodule
`default_nettype wire
